@@ rtl/tlcs_pkg.sv @@
// tlcs_pkg: shared types, constants and character codes of the character-step lexer
`default_nettype none
package tlcs_pkg;

	localparam int MAX_TOKEN_BYTES = 1023;
	localparam int LEN_W = $clog2(MAX_TOKEN_BYTES + 1);

	// one source byte yields at most three result items
	localparam int SLOTS = 3;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int SLOT_W = $clog2(SLOTS);

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_UNDER  = 8'h5f;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_TAB    = 8'h09;

	typedef enum logic [2:0] {
		K_STRING = 3'd0,
		K_NUMBER = 3'd1,
		K_IDENT  = 3'd2,
		K_OPER   = 3'd3,
		K_ERROR  = 3'd4,
		K_END    = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_PREFIX  = 3'd1,
		M_STRING  = 3'd2,
		M_ESCAPE  = 3'd3,
		M_UNICODE = 3'd4,
		M_NUMBER  = 3'd5,
		M_IDENT   = 3'd6
	} lex_mode_t;

	typedef struct packed {
		lex_mode_t        mode;
		logic [7:0]       pfx;
		logic [2:0]       rcl;
		logic [LEN_W-1:0] len;
		logic             exc;
	} lex_state_t;

	localparam lex_state_t LEX_IDLE = '{
		mode: M_IDLE, pfx: 8'h00, rcl: 3'd0, len: '0, exc: 1'b0
	};

	typedef struct packed {
		logic [7:0] ch;
		logic       at_end;
	} char_item_t;

	typedef struct packed {
		kind_t      kind;
		logic       has_byte;
		logic [7:0] value_byte;
		logic       token_end;
		logic       overflow;
		logic       last;
	} tok_item_t;

	typedef struct packed {
		logic [CNT_W-1:0]          cnt;
		tok_item_t [SLOTS-1:0]     items;
	} bundle_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c inside {[8'h09:8'h0d]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c inside {[8'h41:8'h5a]}) || (c inside {[8'h61:8'h7a]});
	endfunction

	function automatic logic is_oper(input logic [7:0] c);
		return c inside {8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h3d, 8'h3c, 8'h3e, 8'h21, 8'h26,
			8'h7c};
	endfunction

endpackage
`default_nettype wire

@@ rtl/tlcs_front.sv @@
// tlcs_front: takes source bytes, runs the lexer state and builds the result bundle
`default_nettype none
module tlcs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_stall,
	input  tlcs_pkg::char_item_t char_item,
	input  logic                 q_full,
	output logic                 q_push,
	output tlcs_pkg::bundle_t    q_bundle
);
	import tlcs_pkg::*;

	lex_state_t st_q;
	lex_state_t st_d;
	bundle_t    bnd;
	logic       accept;

	function automatic void emit(inout bundle_t b, input kind_t k, input logic has,
			input logic [7:0] v, input logic e, input logic o);
		b.items[b.cnt[SLOT_W-1:0]] = '{
			kind: k, has_byte: has, value_byte: (has ? v : 8'h00),
			token_end: e, overflow: (e & o), last: 1'b0
		};
		b.cnt = b.cnt + CNT_W'(1);
	endfunction

	function automatic void push_byte(inout lex_state_t s, inout bundle_t b, input kind_t k,
			input logic [7:0] c);
		if (s.len < LEN_W'(MAX_TOKEN_BYTES)) begin
			emit(b, k, 1'b1, c, 1'b0, 1'b0);
			s.len = s.len + LEN_W'(1);
		end else begin
			s.exc = 1'b1;
		end
	endfunction

	function automatic void finish(inout lex_state_t s, inout bundle_t b, input kind_t k);
		emit(b, k, 1'b0, 8'h00, 1'b1, s.exc);
		s = LEX_IDLE;
	endfunction

	function automatic void start(inout lex_state_t s, inout bundle_t b, input logic [7:0] c);
		s = LEX_IDLE;
		if (!is_space(c)) begin
			if (c == CH_U || c == CH_B || c == CH_R) begin
				s.mode = M_PREFIX;
				s.pfx = c;
			end else if (is_digit(c)) begin
				s.mode = M_NUMBER;
				push_byte(s, b, K_NUMBER, c);
			end else if (is_alpha(c) || c == CH_UNDER) begin
				s.mode = M_IDENT;
				push_byte(s, b, K_IDENT, c);
			end else if (is_oper(c)) begin
				emit(b, K_OPER, 1'b1, c, 1'b1, 1'b0);
			end else begin
				emit(b, K_ERROR, 1'b1, c, 1'b1, 1'b0);
			end
		end
	endfunction

	always_comb begin
		st_d = st_q;
		bnd = '0;
		if (char_item.at_end) begin
			case (st_d.mode)
				M_PREFIX: begin
					push_byte(st_d, bnd, K_IDENT, st_d.pfx);
					finish(st_d, bnd, K_IDENT);
				end
				M_STRING, M_ESCAPE, M_UNICODE: finish(st_d, bnd, K_STRING);
				M_NUMBER: finish(st_d, bnd, K_NUMBER);
				M_IDENT: finish(st_d, bnd, K_IDENT);
				default: ;
			endcase
			emit(bnd, K_END, 1'b0, 8'h00, 1'b1, 1'b0);
			st_d = LEX_IDLE;
		end else begin
			case (st_d.mode)
				M_PREFIX: begin
					if (char_item.ch == CH_QUOTE) begin
						st_d.mode = M_STRING;
						push_byte(st_d, bnd, K_STRING, st_d.pfx);
					end else begin
						st_d.mode = M_IDENT;
						push_byte(st_d, bnd, K_IDENT, st_d.pfx);
						if (is_alpha(char_item.ch) || is_digit(char_item.ch) ||
								char_item.ch == CH_UNDER) begin
							push_byte(st_d, bnd, K_IDENT, char_item.ch);
						end else begin
							finish(st_d, bnd, K_IDENT);
							start(st_d, bnd, char_item.ch);
						end
					end
				end
				M_STRING: begin
					if (char_item.ch == CH_QUOTE) begin
						finish(st_d, bnd, K_STRING);
					end else if (char_item.ch == CH_BSLASH && st_d.pfx != CH_R) begin
						st_d.mode = M_ESCAPE;
					end else begin
						push_byte(st_d, bnd, K_STRING, char_item.ch);
					end
				end
				M_ESCAPE: begin
					st_d.mode = M_STRING;
					if (char_item.ch == CH_N) begin
						push_byte(st_d, bnd, K_STRING, CH_LF);
					end else if (char_item.ch == CH_T) begin
						push_byte(st_d, bnd, K_STRING, CH_TAB);
					end else if (char_item.ch == CH_U) begin
						st_d.mode = M_UNICODE;
						st_d.rcl = 3'd4;
					end else begin
						push_byte(st_d, bnd, K_STRING, char_item.ch);
					end
				end
				M_UNICODE: begin
					push_byte(st_d, bnd, K_STRING, char_item.ch);
					st_d.rcl = st_d.rcl - 3'd1;
					if (st_d.rcl == 3'd0 || st_d.rcl > 3'd4) begin
						st_d.rcl = 3'd0;
						st_d.mode = M_STRING;
					end
				end
				M_NUMBER: begin
					if (is_alpha(char_item.ch) || is_digit(char_item.ch) ||
							char_item.ch == CH_DOT) begin
						push_byte(st_d, bnd, K_NUMBER, char_item.ch);
					end else begin
						finish(st_d, bnd, K_NUMBER);
						start(st_d, bnd, char_item.ch);
					end
				end
				M_IDENT: begin
					if (is_alpha(char_item.ch) || is_digit(char_item.ch) ||
							char_item.ch == CH_UNDER) begin
						push_byte(st_d, bnd, K_IDENT, char_item.ch);
					end else begin
						finish(st_d, bnd, K_IDENT);
						start(st_d, bnd, char_item.ch);
					end
				end
				default: start(st_d, bnd, char_item.ch);
			endcase
		end
		// flag the final item of this byte
		if (bnd.cnt != '0) begin
			bnd.items[SLOT_W'(bnd.cnt - CNT_W'(1))].last = 1'b1;
		end
	end

	assign char_stall = q_full;
	assign accept = char_valid && !char_stall;
	assign q_push = accept && (bnd.cnt != '0);
	assign q_bundle = bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= LEX_IDLE;
		end else if (accept) begin
			st_q <= st_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/tlcs_queue.sv @@
// tlcs_queue: short queue of result bundles between the lexer front and the output stage
`default_nettype none
module tlcs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tlcs_pkg::bundle_t push_bundle,
	output logic              full,
	output logic              head_valid,
	output tlcs_pkg::bundle_t head,
	input  logic              pop
);
	import tlcs_pkg::*;

	bundle_t        mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;

	assign full = (cnt_q == (QAW + 1)'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QAW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QAW + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QAW + 1)'(1);
			end
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("pop from empty queue");
	a_push_items: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_bundle.cnt != '0))
		else $error("empty bundle pushed");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(!head_valid || full) |-> (wr_q == rd_q))
		else $error("queue pointers disagree with fill count");

endmodule
`default_nettype wire

@@ rtl/tlcs_back.sv @@
// tlcs_back: unpacks bundles into single result items through the output register
`default_nettype none
module tlcs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  tlcs_pkg::bundle_t   head,
	output logic                pop,
	output logic                tok_valid,
	input  logic                tok_stall,
	output tlcs_pkg::tok_item_t tok_item
);
	import tlcs_pkg::*;

	logic [SLOT_W-1:0] idx_q;
	logic              tok_valid_q;
	tok_item_t         tok_item_q;
	tok_item_t         cur;
	logic              load;

	assign cur = head.items[idx_q];
	assign load = !tok_valid_q || !tok_stall;
	assign pop = load && head_valid && cur.last;
	assign tok_valid = tok_valid_q;
	assign tok_item = tok_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			tok_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= cur.last ? '0 : idx_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			tok_item_q <= cur;
		end
	end

endmodule
`default_nettype wire

@@ rtl/token_lexer_char_step.sv @@
// token_lexer_char_step: top level of the streaming byte-at-a-time lexer
// path: a source byte's result items are written into the queue, then loaded into the output register
// throughput: one source byte per cycle while each byte yields at most one item and tok_stall stays low
// a byte that yields k items holds the output stage until all k have left; a four-bundle queue absorbs it
// reset: asynchronous, active low; lexer returns to idle and the queue and output empty
`default_nettype none
module token_lexer_char_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_stall,
	input  tlcs_pkg::char_item_t char_item,
	output logic                 tok_valid,
	input  logic                 tok_stall,
	output tlcs_pkg::tok_item_t  tok_item
);
	import tlcs_pkg::*;

	logic    q_push;
	logic    q_full;
	logic    q_pop;
	logic    q_valid;
	bundle_t q_in;
	bundle_t q_head;

	tlcs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_bundle   (q_in)
	);

	tlcs_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (q_push),
		.push_bundle (q_in),
		.full        (q_full),
		.head_valid  (q_valid),
		.head        (q_head),
		.pop         (q_pop)
	);

	tlcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.tok_item   (tok_item)
	);

endmodule
`default_nettype wire
